// ===== hw/rtl/fsgm_pkg.sv =====
// Package for the frame sequence gap monitor.
// Holds widths, event and register codes and the remainder unit status type.
// Depends on nothing; every other file of the block uses it.
package fsgm_pkg;

  localparam int unsigned FRAME_BITS = 24;
  localparam int unsigned FPS_W      = 25;
  localparam int unsigned THR_W      = 11;
  localparam int unsigned SEC_W      = 30;
  localparam int unsigned TOT_W      = 32;
  localparam int unsigned FC_W       = 48;
  localparam int unsigned CFG_W      = 25;
  localparam int unsigned SUM_W      = ((FRAME_BITS > FPS_W) ? FRAME_BITS : FPS_W) + 1;
  localparam int unsigned STEP_W     = $clog2(SUM_W);

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_GAP  = 2'd1,
    EV_FEW  = 2'd2,
    EV_MANY = 2'd3
  } event_e;

  typedef enum logic {
    CFG_FPS     = 1'b0,
    CFG_THREADS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

// ===== hw/rtl/fsgm_in_if.sv =====
// Request channel carrying one frame header.
// Depends on fsgm_pkg for the field widths.
interface fsgm_in_if;
  logic                             valid;
  logic                             ready;
  logic [fsgm_pkg::FRAME_BITS-1:0]  frame_number;
  logic [fsgm_pkg::SEC_W-1:0]       second_count;

  modport source (output valid, output frame_number, output second_count, input ready);
  modport sink   (input valid, input frame_number, input second_count, output ready);
endinterface

// Result channel carrying one classification and the running totals.
// Depends on fsgm_pkg for the field widths.
interface fsgm_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       event_code;
  logic [fsgm_pkg::FRAME_BITS-1:0]  previous_frame;
  logic [fsgm_pkg::THR_W-1:0]       threads_seen;
  logic                             second_report;
  logic [fsgm_pkg::TOT_W-1:0]       gaps_total;
  logic [fsgm_pkg::TOT_W-1:0]       too_few_total;
  logic [fsgm_pkg::TOT_W-1:0]       too_many_total;
  logic [fsgm_pkg::FC_W-1:0]        frames_before;
  logic [fsgm_pkg::SEC_W-1:0]       duration_seconds;

  modport source (output valid, output event_code, output previous_frame, output threads_seen,
                  output second_report, output gaps_total, output too_few_total,
                  output too_many_total, output frames_before, output duration_seconds,
                  input ready);
  modport sink   (input valid, input event_code, input previous_frame, input threads_seen,
                  input second_report, input gaps_total, input too_few_total,
                  input too_many_total, input frames_before, input duration_seconds,
                  output ready);
endinterface

// ===== hw/rtl/fsgm_mod_unit.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on fsgm_pkg for widths and the status struct.
module fsgm_mod_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fsgm_pkg::SUM_W-1:0]    dividend_i,
  input  logic [fsgm_pkg::FPS_W-1:0]    divisor_i,
  output logic [fsgm_pkg::FPS_W-1:0]    rem_o,
  output fsgm_pkg::mod_status_t         status_o
);
  import fsgm_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic [FPS_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  dvd_q;
  logic [FPS_W-1:0]  dsr_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [FPS_W:0]    shifted;
  logic [FPS_W:0]    diff;

  always_comb begin
    shifted = {rem_q, dvd_q[SUM_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    if (shifted >= {1'b0, dsr_q}) begin
      rem_d = diff[FPS_W-1:0];
    end else begin
      rem_d = shifted[FPS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
    end
  end

  assign rem_o         = rem_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ===== hw/rtl/frame_sequence_gap_monitor.sv =====
// Top level of the frame sequence gap monitor: sequencer, state and result register.
// Depends on fsgm_pkg, fsgm_in_if, fsgm_out_if and fsgm_mod_unit.
//
//   channel   direction  handshake        payload
//   in_i      sink       valid / ready    frame_number, second_count
//   out_o     source     valid / ready    event_code ... duration_seconds
//   cfg       write      cfg_we_i         cfg_idx_i, cfg_data_i
//
// A header that changes a held frame number, with a nonzero frames_per_second
// and a nonnegative step, goes through S_CALC, where the remainder modulo
// frames_per_second is found one bit per cycle over 26 steps in the remainder
// unit. One header is in work at a time. Reset clears the sequencer, the
// counters and the held frame; frames_per_second and expected_threads reset
// to one. A stalled result holds in the output register while the next
// request is taken, and the sequencer waits before writing over it.
module frame_sequence_gap_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [fsgm_pkg::CFG_W-1:0]    cfg_data_i,
  fsgm_in_if.sink                       in_i,
  fsgm_out_if.source                    out_o
);
  import fsgm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_CALC = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [FPS_W-1:0]      fps_q;
  logic [THR_W-1:0]      exp_q;
  logic [FRAME_BITS-1:0] last_q;
  logic                  have_q;
  logic [THR_W-1:0]      thr_q;
  logic [SEC_W-1:0]      start_q;
  logic [TOT_W-1:0]      gap_cnt_q, few_cnt_q, many_cnt_q;
  logic [FC_W-1:0]       fc_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [SEC_W-1:0]      secs_q;
  logic                  use_mod_q;

  logic                  out_valid_q;
  event_e                ev_out_q;
  logic [FRAME_BITS-1:0] prev_out_q;
  logic [THR_W-1:0]      thr_out_q;
  logic                  rep_out_q;
  logic [FC_W-1:0]       fc_out_q;
  logic [SEC_W-1:0]      dur_out_q;

  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      last_ext;
  logic                  neg;
  logic [SUM_W-1:0]      dividend;
  logic                  mod_start;
  logic [FPS_W-1:0]      rem;
  mod_status_t           mod_st;

  logic                  changed;
  logic                  is_gap;
  logic                  commit;
  event_e                ev;
  logic [THR_W-1:0]      thr_base;
  logic [SEC_W-1:0]      start_new;

  assign last_ext = SUM_W'(last_q);
  assign sum      = SUM_W'(frame_q) + SUM_W'(fps_q);
  assign neg      = sum < last_ext;
  assign dividend = sum - last_ext;
  assign changed  = !have_q || (frame_q != last_q);

  assign mod_start = state_q == S_PREP && use_mod_q && have_q && changed &&
                     fps_q != '0 && !neg;

  fsgm_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (dividend),
    .divisor_i  (fps_q),
    .rem_o      (rem),
    .status_o   (mod_st)
  );

  assign is_gap = (fps_q == '0) || neg || (rem != FPS_W'(1));
  assign commit = state_q == S_DONE && (!out_valid_q || out_o.ready);

  always_comb begin
    ev = EV_NONE;
    if (have_q && changed) begin
      priority if (is_gap) begin
        ev = EV_GAP;
      end else if (thr_q < exp_q) begin
        ev = EV_FEW;
      end else if (thr_q > exp_q) begin
        ev = EV_MANY;
      end else begin
        ev = EV_NONE;
      end
    end
    thr_base  = changed ? '0 : thr_q;
    start_new = have_q ? start_q : secs_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = mod_start ? S_CALC : S_DONE;
      end
      S_CALC: begin
        if (mod_st.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_i.ready = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fps_q       <= FPS_W'(1);
      exp_q       <= THR_W'(1);
      last_q      <= '0;
      have_q      <= 1'b0;
      thr_q       <= '0;
      start_q     <= '0;
      gap_cnt_q   <= '0;
      few_cnt_q   <= '0;
      many_cnt_q  <= '0;
      fc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_FPS:     fps_q <= cfg_data_i[FPS_W-1:0];
          CFG_THREADS: exp_q <= cfg_data_i[THR_W-1:0];
          default:     fps_q <= fps_q;
        endcase
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        if (ev == EV_GAP && gap_cnt_q != '1) begin
          gap_cnt_q <= gap_cnt_q + 1'b1;
        end
        if (ev == EV_FEW && few_cnt_q != '1) begin
          few_cnt_q <= few_cnt_q + 1'b1;
        end
        if (ev == EV_MANY && many_cnt_q != '1) begin
          many_cnt_q <= many_cnt_q + 1'b1;
        end
        thr_q   <= (thr_base != '1) ? thr_base + 1'b1 : thr_base;
        fc_q    <= (fc_q != '1) ? fc_q + 1'b1 : fc_q;
        last_q  <= frame_q;
        have_q  <= 1'b1;
        start_q <= start_new;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      frame_q   <= in_i.frame_number;
      secs_q    <= in_i.second_count;
      use_mod_q <= 1'b0;
    end else if (state_q == S_PREP) begin
      use_mod_q <= 1'b0;
    end
    if (state_q == S_IDLE && in_i.valid) begin
      use_mod_q <= 1'b1;
    end
    if (commit) begin
      ev_out_q   <= ev;
      prev_out_q <= last_q;
      thr_out_q  <= thr_q;
      rep_out_q  <= changed && (!have_q || last_q > frame_q);
      fc_out_q   <= fc_q;
      dur_out_q  <= secs_q - start_new;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.event_code       = ev_out_q;
  assign out_o.previous_frame   = prev_out_q;
  assign out_o.threads_seen     = thr_out_q;
  assign out_o.second_report    = rep_out_q;
  assign out_o.gaps_total       = gap_cnt_q;
  assign out_o.too_few_total    = few_cnt_q;
  assign out_o.too_many_total   = many_cnt_q;
  assign out_o.frames_before    = fc_out_q;
  assign out_o.duration_seconds = dur_out_q;

endmodule

// ===== tb/frame_sequence_gap_monitor_tb.sv =====
// Self-checking testbench for the frame sequence gap monitor.
// Drives frame headers and checks every result against a built-in predictor.
// Depends on fsgm_pkg, fsgm_in_if, fsgm_out_if and frame_sequence_gap_monitor.
module frame_sequence_gap_monitor_tb;
  import fsgm_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;

  typedef struct packed {
    logic [1:0]            event_code;
    logic [FRAME_BITS-1:0] previous_frame;
    logic [THR_W-1:0]      threads_seen;
    logic                  second_report;
    logic [TOT_W-1:0]      gaps_total;
    logic [TOT_W-1:0]      too_few_total;
    logic [TOT_W-1:0]      too_many_total;
    logic [FC_W-1:0]       frames_before;
    logic [SEC_W-1:0]      duration_seconds;
  } report_t;

  class gap_report_board;
    bit [FPS_W-1:0]      frames_per_second;
    bit [THR_W-1:0]      expected_threads;
    bit [FRAME_BITS-1:0] last_frame;
    bit                  have_frame;
    bit [THR_W-1:0]      thread_count;
    bit [SEC_W-1:0]      start_second;
    bit [TOT_W-1:0]      gaps;
    bit [TOT_W-1:0]      few;
    bit [TOT_W-1:0]      many;
    bit [FC_W-1:0]       headers;
    report_t             pending_reports[$];
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         wraps_seen;
    int unsigned         event_hits[4];

    function new();
      frames_per_second = 1;
      expected_threads  = 1;
    endfunction

    function void write_register(cfg_idx_e idx, bit [CFG_W-1:0] value);
      if (idx == CFG_FPS) begin
        frames_per_second = value[FPS_W-1:0];
      end else begin
        expected_threads = value[THR_W-1:0];
      end
    endfunction

    function bit [TOT_W-1:0] bump(bit [TOT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function bit step_is_gap(bit [FRAME_BITS-1:0] frame);
      bit [SUM_W-1:0] sum;
      if (frames_per_second == 0) return 1'b1;
      sum = frame + frames_per_second;
      if (sum < last_frame) return 1'b1;
      return ((sum - last_frame) % frames_per_second) != 1;
    endfunction

    function void note_header(bit [FRAME_BITS-1:0] frame, bit [SEC_W-1:0] secs);
      report_t r;
      r = '0;
      r.event_code     = EV_NONE;
      r.previous_frame = last_frame;
      r.threads_seen   = thread_count;
      r.frames_before  = headers;
      if (!have_frame || frame != last_frame) begin
        if (have_frame) begin
          if (step_is_gap(frame)) begin
            r.event_code = EV_GAP;
            gaps = bump(gaps);
          end else if (thread_count < expected_threads) begin
            r.event_code = EV_FEW;
            few = bump(few);
          end else if (thread_count > expected_threads) begin
            r.event_code = EV_MANY;
            many = bump(many);
          end
        end else begin
          start_second = secs;
        end
        r.second_report = !have_frame || (last_frame > frame);
        thread_count = '0;
        last_frame   = frame;
        have_frame   = 1'b1;
      end
      if (thread_count != '1) thread_count++;
      if (headers != '1) headers++;
      r.gaps_total       = gaps;
      r.too_few_total    = few;
      r.too_many_total   = many;
      r.duration_seconds = secs - start_second;
      pending_reports.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        $error("result arrived with no request waiting");
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      checked++;
      event_hits[want.event_code]++;
      if (want.second_report) wraps_seen++;
      compare("event_code", want.event_code, got.event_code);
      compare("previous_frame", want.previous_frame, got.previous_frame);
      compare("threads_seen", want.threads_seen, got.threads_seen);
      compare("second_report", want.second_report, got.second_report);
      compare("gaps_total", want.gaps_total, got.gaps_total);
      compare("too_few_total", want.too_few_total, got.too_few_total);
      compare("too_many_total", want.too_many_total, got.too_many_total);
      compare("frames_before", want.frames_before, got.frames_before);
      compare("duration_seconds", want.duration_seconds, got.duration_seconds);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  fsgm_in_if  in_if ();
  fsgm_out_if out_if ();

  frame_sequence_gap_monitor u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  gap_report_board board = new();

  int unsigned         idle_odds;
  bit                  calm_tail;
  int unsigned         cur_fps;
  int unsigned         cur_thr;
  logic [SEC_W-1:0]    cur_secs;
  logic [FRAME_BITS-1:0] last_sent;
  int unsigned         headers_sent;
  int unsigned         settings_done;
  report_t             observed;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      board.note_header(in_if.frame_number, in_if.second_count);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      observed = '{out_if.event_code, out_if.previous_frame, out_if.threads_seen,
                   out_if.second_report, out_if.gaps_total, out_if.too_few_total,
                   out_if.too_many_total, out_if.frames_before, out_if.duration_seconds};
      board.check_report(observed);
    end
  end

  initial begin
    int unsigned hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, 15) < idle_odds) begin
        hold = $urandom_range(1, 12) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $error("no request or result moved for %0d cycles", STALL_LIMIT);
    $display("FAIL frame_sequence_gap_monitor");
    $finish;
  end

  function automatic logic [FRAME_BITS-1:0] following(input logic [FRAME_BITS-1:0] f);
    if (cur_fps == 0) return f + 1'b1;
    return FRAME_BITS'((32'(f) + 1) % cur_fps);
  endfunction

  function automatic int unsigned frame_span();
    if (cur_fps == 0 || cur_fps > 2 ** FRAME_BITS) return 2 ** FRAME_BITS;
    return cur_fps;
  endfunction

  task automatic send_header(input logic [FRAME_BITS-1:0] frame,
                             input logic [SEC_W-1:0] secs);
    if (idle_odds != 0 && $urandom_range(0, 15) < idle_odds) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.frame_number <= frame;
    in_if.second_count <= secs;
    do @(posedge clk_i); while (!in_if.ready);
    last_sent = frame;
    headers_sent++;
  endtask

  task automatic apply_setting(input int unsigned fps, input int unsigned threads);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FPS;
    cfg_data_i <= fps[CFG_W-1:0];
    @(posedge clk_i);
    board.write_register(CFG_FPS, fps[CFG_W-1:0]);
    cfg_idx_i  <= CFG_THREADS;
    cfg_data_i <= threads[CFG_W-1:0];
    @(posedge clk_i);
    board.write_register(CFG_THREADS, threads[CFG_W-1:0]);
    cfg_we_i <= 1'b0;
    cur_fps = 32'(fps[FPS_W-1:0]);
    cur_thr = 32'(threads[THR_W-1:0]);
    settings_done++;
  endtask

  task automatic send_sequence();
    int unsigned span;
    int unsigned reps;
    logic [FRAME_BITS-1:0] f;
    logic [FRAME_BITS-1:0] nxt;
    span = frame_span();
    if ($urandom_range(0, 1)) begin
      f = FRAME_BITS'(span - $urandom_range(1, (span < 8) ? span : 8));
    end else begin
      f = FRAME_BITS'($urandom_range(0, span - 1));
    end
    repeat ($urandom_range(2, 8)) begin
      reps = (cur_thr == 0) ? 1 : ((cur_thr > 12) ? $urandom_range(1, 12) : cur_thr);
      case ($urandom_range(0, 7))
        0: reps = reps + 1;
        1: if (reps > 1) reps = reps - 1;
        default: ;
      endcase
      repeat (reps) send_header(f, cur_secs);
      nxt = following(f);
      if (nxt < f) cur_secs++;
      f = nxt;
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_header(FRAME_BITS'($urandom), SEC_W'($urandom));
      1: send_header(FRAME_BITS'(last_sent + $urandom_range(2, 5)), cur_secs);
      2: send_header(FRAME_BITS'(last_sent - $urandom_range(1, 3)), cur_secs);
      default: repeat ($urandom_range(2, 6)) send_header(last_sent, SEC_W'($urandom));
    endcase
  endtask

  task automatic run_phase(input int unsigned fps, input int unsigned threads,
                           input int unsigned count);
    int unsigned first;
    apply_setting(fps, threads);
    first = headers_sent;
    while (headers_sent - first < count) begin
      idle_odds = calm_tail ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 9) < 7) begin
        send_sequence();
      end else begin
        send_noise();
      end
    end
  endtask

  task automatic send_long_frame(input int unsigned count);
    logic [FRAME_BITS-1:0] f;
    f = following(last_sent);
    repeat (count) send_header(f, cur_secs);
    send_header(following(f), cur_secs);
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_FPS;
    cfg_data_i         <= '0;
    in_if.valid        <= 1'b0;
    in_if.frame_number <= '0;
    in_if.second_count <= '0;
    idle_odds = 2;
    calm_tail = 1'b0;
    cur_secs  = SEC_W'($urandom);
    last_sent = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: first header, repeats, a normal step, too few and too many
    // threads, a wrap, a forward gap, the largest frame number and a negative step.
    apply_setting(4, 2);
    send_header(0, '1);
    send_header(0, '0);
    send_header(1, 5);
    send_header(1, 5);
    send_header(2, 5);
    send_header(3, 5);
    send_header(3, 6);
    send_header(3, 6);
    send_header(3, 6);
    send_header(0, 6);
    send_header(2, 6);
    send_header('1, '1);
    send_header(0, '0);
    send_header(1, 0);
    send_header(1, 0);

    run_phase(1, 1, 90);
    run_phase(0, 0, 90);
    run_phase(10, 3, 100);
    run_phase(16777216, 2, 90);
    run_phase(33554431, 1, 70);
    run_phase(2, 4, 90);

    // Frames that carry many headers, against a small and a large expected count.
    apply_setting(3, 40);
    send_long_frame(40);
    send_long_frame(60);
    run_phase(5, 2047, 50);
    send_long_frame(50);

    calm_tail = 1'b1;
    idle_odds = 0;
    run_phase(7, 2, 120);

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_reports.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Checked %0d results over %0d register settings.", board.checked, settings_done);
    $display("Events: %0d none, %0d gaps, %0d too few, %0d too many, %0d second reports.",
             board.event_hits[EV_NONE], board.event_hits[EV_GAP], board.event_hits[EV_FEW],
             board.event_hits[EV_MANY], board.wraps_seen);
    if (board.mismatches == 0 && board.pending_reports.size() == 0) begin
      $display("PASS frame_sequence_gap_monitor");
    end else begin
      $display("FAIL frame_sequence_gap_monitor");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fsgm_pkg.sv
hw/rtl/fsgm_in_if.sv
hw/rtl/fsgm_mod_unit.sv
hw/rtl/frame_sequence_gap_monitor.sv
tb/frame_sequence_gap_monitor_tb.sv
